>>> design/ilpm_pkg.sv
// shared types, widths and register codes for the low-pass frequency mask
`timescale 1ns / 1ps
`default_nettype none
package ilpm_pkg;

  localparam int INDEX_BITS = 12;
  localparam int MID_W      = 13;
  localparam int SCALE_W    = 32;
  localparam int FRAC_BITS  = 24;
  localparam int WORD_W     = 32;
  localparam int NUM_AXES   = 3;
  localparam int NUM_REGS   = 6;
  localparam int CFG_IDX_W  = 3;

  // folded distance covers both the index and the doubled midpoint
  localparam int DIST_W = (INDEX_BITS > MID_W) ? INDEX_BITS : MID_W;
  localparam int CMP_W  = DIST_W + 1;
  localparam int PROD_W = DIST_W + SCALE_W;
  localparam int TERM_W = FRAC_BITS + 2;
  localparam int SQ_W   = 2 * TERM_W;
  localparam int SUM_W  = SQ_W + 2;

  localparam logic [PROD_W-1:0] TWO_Q24 = PROD_W'(2) << FRAC_BITS;
  localparam logic [SUM_W-1:0]  ONE_Q48 = SUM_W'(1) << (2 * FRAC_BITS);

  localparam logic [MID_W-1:0] MID_RESET = MID_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MID   = 3'd0,
    REG_Y_MID   = 3'd1,
    REG_Z_MID   = 3'd2,
    REG_X_SCALE = 3'd3,
    REG_Y_SCALE = 3'd4,
    REG_Z_SCALE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][MID_W-1:0]   mid_doubled;
    logic [NUM_AXES-1:0][SCALE_W-1:0] scale;
  } cfg_t;

  // load enables of the three axis stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage
`default_nettype wire

>>> design/ideal_lowpass_frequency_mask_core.sv
// ideal low-pass mask over a 3-d spectrum, top level with handshake and sum stage
// throughput: one word per cycle while out_stall is low; four stages (fold,
//   scale multiply, clamp+square, sum+compare) each hold a valid bit and fill
//   bubbles independently
// reset (rst_n low, synchronous): pipeline emptied, doubled midpoints 4096, scales 0
`timescale 1ns / 1ps
`default_nettype none
module ideal_lowpass_frequency_mask_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [ilpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ilpm_pkg::SCALE_W-1:0]     cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [ilpm_pkg::INDEX_BITS-1:0]  in_x_index,
  input  wire logic [ilpm_pkg::INDEX_BITS-1:0]  in_y_index,
  input  wire logic [ilpm_pkg::INDEX_BITS-1:0]  in_z_index,
  input  wire logic [ilpm_pkg::WORD_W-1:0]      in_real_in,
  input  wire logic [ilpm_pkg::WORD_W-1:0]      in_imag_in,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ilpm_pkg::WORD_W-1:0]           out_real_out,
  output logic [ilpm_pkg::WORD_W-1:0]           out_imag_out,
  output logic                                  out_inside_band
);

  ilpm_pkg::cfg_t     cfg;
  ilpm_pkg::pipe_en_t en;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_out;

  logic [ilpm_pkg::WORD_W-1:0] re1_r, re2_r, re3_r, im1_r, im2_r, im3_r;
  logic [ilpm_pkg::WORD_W-1:0] real_out_r, imag_out_r;
  logic                        inside_r, inside_nxt;

  logic [ilpm_pkg::SQ_W-1:0]  sq_x, sq_y, sq_z;
  logic [ilpm_pkg::SUM_W-1:0] sum;

  ilpm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // a stage loads when it is empty or its word moves on
  assign rdy_out = !out_valid_r || !out_stall;
  assign rdy3    = !v3_r || rdy_out;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  ilpm_axis u_axis_x (
    .clk         (clk),
    .en          (en),
    .idx         (in_x_index),
    .mid_doubled (cfg.mid_doubled[0]),
    .scale       (cfg.scale[0]),
    .sq          (sq_x)
  );

  ilpm_axis u_axis_y (
    .clk         (clk),
    .en          (en),
    .idx         (in_y_index),
    .mid_doubled (cfg.mid_doubled[1]),
    .scale       (cfg.scale[1]),
    .sq          (sq_y)
  );

  ilpm_axis u_axis_z (
    .clk         (clk),
    .en          (en),
    .idx         (in_z_index),
    .mid_doubled (cfg.mid_doubled[2]),
    .scale       (cfg.scale[2]),
    .sq          (sq_z)
  );

  assign sum        = ilpm_pkg::SUM_W'(sq_x) + ilpm_pkg::SUM_W'(sq_y)
                    + ilpm_pkg::SUM_W'(sq_z);
  assign inside_nxt = (sum <= ilpm_pkg::ONE_Q48);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      re1_r <= in_real_in;
      im1_r <= in_imag_in;
    end
    if (rdy2) begin
      re2_r <= re1_r;
      im2_r <= im1_r;
    end
    if (rdy3) begin
      re3_r <= re2_r;
      im3_r <= im2_r;
    end
    if (rdy_out) begin
      inside_r   <= inside_nxt;
      real_out_r <= inside_nxt ? re3_r : '0;
      imag_out_r <= inside_nxt ? im3_r : '0;
    end
  end

  assign in_stall        = !rdy1;
  assign out_valid       = out_valid_r;
  assign out_real_out    = real_out_r;
  assign out_imag_out    = imag_out_r;
  assign out_inside_band = inside_r;

  // an accepted word lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted word did not enter the fold stage");

  // a word in the last axis stage is kept while the output is blocked
  a_stage3_held: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !rdy_out |=> v3_r && $stable(re3_r) && $stable(im3_r))
    else $error("square stage word lost under stall");

  // a new result only comes from a valid square stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v3_r))
    else $error("result appeared without a source word");

  // outside the band both words are zero
  a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !inside_r |-> real_out_r == '0 && imag_out_r == '0)
    else $error("masked sample carries nonzero data");

endmodule
`default_nettype wire

>>> design/ilpm_cfg.sv
// configuration register file for midpoints and scale factors
`timescale 1ns / 1ps
`default_nettype none
module ilpm_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ilpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ilpm_pkg::SCALE_W-1:0]    cfg_wdata,
  output ilpm_pkg::cfg_t                       cfg
);

  ilpm_pkg::cfg_t cfg_r;
  ilpm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        ilpm_pkg::REG_X_MID:   cfg_nxt.mid_doubled[0] = cfg_wdata[ilpm_pkg::MID_W-1:0];
        ilpm_pkg::REG_Y_MID:   cfg_nxt.mid_doubled[1] = cfg_wdata[ilpm_pkg::MID_W-1:0];
        ilpm_pkg::REG_Z_MID:   cfg_nxt.mid_doubled[2] = cfg_wdata[ilpm_pkg::MID_W-1:0];
        ilpm_pkg::REG_X_SCALE: cfg_nxt.scale[0] = cfg_wdata;
        ilpm_pkg::REG_Y_SCALE: cfg_nxt.scale[1] = cfg_wdata;
        ilpm_pkg::REG_Z_SCALE: cfg_nxt.scale[2] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mid_doubled[0] <= ilpm_pkg::MID_RESET;
      cfg_r.mid_doubled[1] <= ilpm_pkg::MID_RESET;
      cfg_r.mid_doubled[2] <= ilpm_pkg::MID_RESET;
      cfg_r.scale          <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> design/ilpm_axis.sv
// one axis: fold, scale, clamp and square over three register stages
`timescale 1ns / 1ps
`default_nettype none
module ilpm_axis (
  input  wire logic                              clk,
  input  wire ilpm_pkg::pipe_en_t                en,
  input  wire logic [ilpm_pkg::INDEX_BITS-1:0]   idx,
  input  wire logic [ilpm_pkg::MID_W-1:0]        mid_doubled,
  input  wire logic [ilpm_pkg::SCALE_W-1:0]      scale,
  output logic [ilpm_pkg::SQ_W-1:0]              sq
);

  logic [ilpm_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic [ilpm_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [ilpm_pkg::SQ_W-1:0]   sq_r, sq_nxt;
  logic [ilpm_pkg::CMP_W-1:0]  idx_e, md_e, idx_dbl;
  logic [ilpm_pkg::TERM_W-1:0] term;

  // fold about the midpoint, magnitude when the index lies past the extent
  always_comb begin
    idx_e   = ilpm_pkg::CMP_W'(idx);
    md_e    = ilpm_pkg::CMP_W'(mid_doubled);
    idx_dbl = idx_e << 1;
    if (idx_dbl > md_e) begin
      if (md_e >= idx_e) begin
        dist_nxt = ilpm_pkg::DIST_W'(md_e - idx_e);
      end else begin
        dist_nxt = ilpm_pkg::DIST_W'(idx_e - md_e);
      end
    end else begin
      dist_nxt = ilpm_pkg::DIST_W'(idx_e);
    end
  end

  assign prod_nxt = ilpm_pkg::PROD_W'(dist_r) * ilpm_pkg::PROD_W'(scale);

  always_comb begin
    if (prod_r > ilpm_pkg::TWO_Q24) begin
      term = ilpm_pkg::TWO_Q24[ilpm_pkg::TERM_W-1:0];
    end else begin
      term = prod_r[ilpm_pkg::TERM_W-1:0];
    end
    sq_nxt = ilpm_pkg::SQ_W'(term) * ilpm_pkg::SQ_W'(term);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dist_r <= dist_nxt;
    end
    if (en.s2) begin
      prod_r <= prod_nxt;
    end
    if (en.s3) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq = sq_r;

endmodule
`default_nettype wire
